// ===== rtl/rfor_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the rectangle fill/outline rasterizer.
// No dependencies; every other file refers to it by scoped names.
package rfor_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [23:0] LOW_COLOR_MASK  = 24'h00FFFF;
    localparam logic [23:0] HIGH_COLOR_BYTE = 24'hFF0000;

    typedef logic [11:0] t_coord;
    typedef logic [12:0] t_pos;
    typedef logic [21:0] t_off;
    typedef logic [23:0] t_color;

    typedef enum logic [2:0] {
        REG_RECT_X      = 3'd0,
        REG_RECT_Y      = 3'd1,
        REG_RECT_W      = 3'd2,
        REG_RECT_H      = 3'd3,
        REG_EXCL_LEFT   = 3'd4,
        REG_EXCL_TOP    = 3'd5,
        REG_EXCL_RIGHT  = 3'd6,
        REG_EXCL_BOTTOM = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_coord rect_x;
        t_coord rect_y;
        t_coord rect_w;
        t_coord rect_h;
        t_coord excl_left;
        t_coord excl_top;
        t_coord excl_right;
        t_coord excl_bottom;
    } t_cfg;

    typedef struct packed {
        logic   active;
        logic   end_scan;
        t_coord col;
        t_coord row;
        logic   outline;
        logic   exclude_on;
        t_color color;
    } t_scan_beat;

endpackage

// ===== rtl/rfor_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the rasterizer: valid/ready plus one request beat.
// Uses rfor_pkg for the color type.
interface rfor_in_if;
    logic            valid;
    logic            ready;
    logic            start_req;
    logic            outline;
    logic            exclude_on;
    rfor_pkg::t_color color;

    modport source (output valid, start_req, outline, exclude_on, color, input ready);
    modport sink   (input valid, start_req, outline, exclude_on, color, output ready);
endinterface

// ===== rtl/rfor_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the rasterizer: valid/ready plus one pixel-write beat.
// Uses rfor_pkg for the offset and color types.
interface rfor_out_if;
    logic             valid;
    logic             ready;
    logic             write_enable;
    rfor_pkg::t_off   byte_offset;
    rfor_pkg::t_color pixel_color;
    logic             last;

    modport source (output valid, write_enable, byte_offset, pixel_color, last, input ready);
    modport sink   (input valid, write_enable, byte_offset, pixel_color, last, output ready);
endinterface

// ===== rtl/rfor_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB register file holding the rectangle and exclusion bounds.
// Depends on rfor_pkg.
module rfor_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rfor_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rfor_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rfor_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output rfor_pkg::t_cfg                   o_cfg
);
    rfor_pkg::t_cfg     r_cfg;
    rfor_pkg::t_reg_idx idx;
    rfor_pkg::t_coord   rd_val;
    rfor_pkg::t_coord   wr_val;
    logic               wr_en;

    assign idx    = rfor_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_val = pwdata[11:0];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (idx)
                rfor_pkg::REG_RECT_X:      r_cfg.rect_x      <= wr_val;
                rfor_pkg::REG_RECT_Y:      r_cfg.rect_y      <= wr_val;
                rfor_pkg::REG_RECT_W:      r_cfg.rect_w      <= wr_val;
                rfor_pkg::REG_RECT_H:      r_cfg.rect_h      <= wr_val;
                rfor_pkg::REG_EXCL_LEFT:   r_cfg.excl_left   <= wr_val;
                rfor_pkg::REG_EXCL_TOP:    r_cfg.excl_top    <= wr_val;
                rfor_pkg::REG_EXCL_RIGHT:  r_cfg.excl_right  <= wr_val;
                rfor_pkg::REG_EXCL_BOTTOM: r_cfg.excl_bottom <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            rfor_pkg::REG_RECT_X:      rd_val = r_cfg.rect_x;
            rfor_pkg::REG_RECT_Y:      rd_val = r_cfg.rect_y;
            rfor_pkg::REG_RECT_W:      rd_val = r_cfg.rect_w;
            rfor_pkg::REG_RECT_H:      rd_val = r_cfg.rect_h;
            rfor_pkg::REG_EXCL_LEFT:   rd_val = r_cfg.excl_left;
            rfor_pkg::REG_EXCL_TOP:    rd_val = r_cfg.excl_top;
            rfor_pkg::REG_EXCL_RIGHT:  rd_val = r_cfg.excl_right;
            rfor_pkg::REG_EXCL_BOTTOM: rd_val = r_cfg.excl_bottom;
            default:                   rd_val = '0;
        endcase
    end

    assign prdata = {20'd0, rd_val};

endmodule

// ===== rtl/rfor_scan_ctrl.sv =====
`timescale 1ns / 1ps
// Scan position state and input stage: steps the column/row on every accepted
// beat of an active scan and registers the position to evaluate. Depends on rfor_pkg, rfor_in_if.
module rfor_scan_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rfor_pkg::t_cfg       i_cfg,
    rfor_in_if.sink              i_in,
    output rfor_pkg::t_scan_beat o_beat,
    output logic                 o_valid,
    input  logic                 i_ready
);
    rfor_pkg::t_coord     r_col;
    rfor_pkg::t_coord     r_row;
    logic                 r_active;
    logic                 r_valid;
    rfor_pkg::t_scan_beat r_beat;

    rfor_pkg::t_coord     n_col;
    rfor_pkg::t_coord     n_row;
    logic                 n_active;
    rfor_pkg::t_scan_beat n_beat;

    rfor_pkg::t_coord     eff_col;
    rfor_pkg::t_coord     eff_row;
    rfor_pkg::t_coord     last_col;
    rfor_pkg::t_coord     last_row;
    logic                 eff_act;
    logic                 end_row;
    logic                 end_scan;
    logic                 accept;

    assign i_in.ready = !r_valid || i_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_beat     = r_beat;

    always_comb begin
        eff_col  = i_in.start_req ? '0 : r_col;
        eff_row  = i_in.start_req ? '0 : r_row;
        eff_act  = (i_in.start_req || r_active) &&
                   (i_cfg.rect_w != '0) && (i_cfg.rect_h != '0);
        last_col = i_cfg.rect_w - 12'd1;
        last_row = i_cfg.rect_h - 12'd1;
        end_row  = eff_col >= last_col;
        end_scan = eff_act && end_row && (eff_row >= last_row);

        if (!eff_act) begin
            n_active = 1'b0;
            n_col    = eff_col;
            n_row    = eff_row;
        end else if (end_scan) begin
            n_active = 1'b0;
            n_col    = '0;
            n_row    = '0;
        end else if (end_row) begin
            n_active = 1'b1;
            n_col    = '0;
            n_row    = eff_row + 12'd1;
        end else begin
            n_active = 1'b1;
            n_col    = eff_col + 12'd1;
            n_row    = eff_row;
        end

        n_beat.active     = eff_act;
        n_beat.end_scan   = end_scan;
        n_beat.col        = eff_col;
        n_beat.row        = eff_row;
        n_beat.outline    = i_in.outline;
        n_beat.exclude_on = i_in.exclude_on;
        n_beat.color      = i_in.color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else if (accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_active <= n_active;
            r_valid  <= 1'b1;
        end else if (i_ready) begin
            r_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= n_beat;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.start_req && (i_cfg.rect_w > 12'd1) && (i_cfg.rect_h != '0))
        |=> (r_active && (r_col == 12'd1) && (r_row == '0)))
        else $error("start on a wide rectangle did not advance to column one");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_active && !i_in.start_req)
        |=> ($stable(r_col) && $stable(r_row) && !r_active))
        else $error("idle beat moved the scan position");
`endif

endmodule

// ===== rtl/rfor_pixel_eval.sv =====
`timescale 1ns / 1ps
// Output stage: decides whether the registered position is drawn, forms the
// byte offset and color, and holds the result beat. Depends on rfor_pkg, rfor_out_if.
module rfor_pixel_eval #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480,
    parameter int PIXEL_BYTES   = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rfor_pkg::t_cfg       i_cfg,
    input  rfor_pkg::t_scan_beat i_beat,
    input  logic                 i_valid,
    output logic                 o_ready,
    rfor_out_if.source           o_out
);
    localparam rfor_pkg::t_pos SW_LIM = 13'(SCREEN_WIDTH);
    localparam rfor_pkg::t_pos SH_LIM = 13'(SCREEN_HEIGHT);
    localparam rfor_pkg::t_off SW_MUL = 22'(SCREEN_WIDTH);

    logic             r_valid;
    logic             r_we;
    rfor_pkg::t_off   r_off;
    rfor_pkg::t_color r_pc;
    logic             r_last;

    logic             n_we;
    rfor_pkg::t_off   n_off;
    rfor_pkg::t_color n_pc;
    logic             n_last;

    rfor_pkg::t_pos   x;
    rfor_pkg::t_pos   y;
    rfor_pkg::t_off   lin;
    rfor_pkg::t_off   off;
    rfor_pkg::t_color pc;
    logic             in_rect;
    logic             border;
    logic             on_screen;
    logic             excluded;
    logic             advance;

    assign o_ready = !r_valid || o_out.ready;
    assign advance = i_valid && o_ready;

    always_comb begin
        x = {1'b0, i_cfg.rect_x} + {1'b0, i_beat.col};
        y = {1'b0, i_cfg.rect_y} + {1'b0, i_beat.row};

        in_rect   = (i_beat.col < i_cfg.rect_w) && (i_beat.row < i_cfg.rect_h);
        border    = (i_beat.col == '0) || (i_beat.col == (i_cfg.rect_w - 12'd1)) ||
                    (i_beat.row == '0) || (i_beat.row == (i_cfg.rect_h - 12'd1));
        on_screen = (x < SW_LIM) && (y < SH_LIM);
        excluded  = i_beat.exclude_on &&
                    (x >= {1'b0, i_cfg.excl_left}) && (x <= {1'b0, i_cfg.excl_right}) &&
                    (y >= {1'b0, i_cfg.excl_top})  && (y <= {1'b0, i_cfg.excl_bottom});

        lin = rfor_pkg::t_off'(x) + rfor_pkg::t_off'(rfor_pkg::t_off'(y) * SW_MUL);
        off = rfor_pkg::t_off'(lin << 1) + ((PIXEL_BYTES >= 3) ? lin : '0);
        pc  = (PIXEL_BYTES >= 3) ?
              ((i_beat.color & rfor_pkg::LOW_COLOR_MASK) |
               (i_beat.color & rfor_pkg::HIGH_COLOR_BYTE)) :
              (i_beat.color & rfor_pkg::LOW_COLOR_MASK);

        n_we   = i_beat.active && in_rect && (!i_beat.outline || border) &&
                 on_screen && !excluded;
        n_off  = n_we ? off : '0;
        n_pc   = n_we ? pc : '0;
        n_last = !i_beat.active || i_beat.end_scan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_we   <= n_we;
            r_off  <= n_off;
            r_pc   <= n_pc;
            r_last <= n_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.write_enable = r_we;
    assign o_out.byte_offset  = r_off;
    assign o_out.pixel_color  = r_pc;
    assign o_out.last         = r_last;

`ifndef NO_ASSERTIONS
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_we) |-> ((r_off == '0) && (r_pc == '0)))
        else $error("skipped pixel carries a nonzero offset or color");
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !i_beat.active) |=> (r_valid && r_last && !r_we))
        else $error("idle beat did not produce an idle result");
`endif

endmodule

// ===== rtl/rect_fill_outline_rasterizer.sv =====
`timescale 1ns / 1ps
// Top level of the rectangle fill/outline rasterizer.
// Depends on rfor_pkg, rfor_in_if, rfor_out_if, rfor_cfg_regs, rfor_scan_ctrl, rfor_pixel_eval.
//
// Each input beat of an active scan steps the scan of the configured rectangle by one
// position, and every input beat yields exactly one result beat (pixel write or skip, byte
// offset relative to the framebuffer base, color, and last). The block sustains one beat
// per clock while the output is not stalled: the scan position register updates in the
// cycle a beat is accepted, the position is held in an input stage register, and the draw
// decision and offset multiply-add land in the output register. The user must write
// configuration over APB only while no beats are in flight; the block does not enforce it.
module rect_fill_outline_rasterizer #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480,
    parameter int PIXEL_BYTES   = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rfor_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rfor_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rfor_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    rfor_in_if.sink                          i_in,
    rfor_out_if.source                       o_out
);
    rfor_pkg::t_cfg       cfg;
    rfor_pkg::t_scan_beat scan_beat;
    logic                 scan_valid;
    logic                 scan_ready;

    rfor_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rfor_scan_ctrl u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_beat  (scan_beat),
        .o_valid (scan_valid),
        .i_ready (scan_ready)
    );

    rfor_pixel_eval #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PIXEL_BYTES   (PIXEL_BYTES)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_beat  (scan_beat),
        .i_valid (scan_valid),
        .o_ready (scan_ready),
        .o_out   (o_out)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rect_fill_outline_rasterizer: directed table, then random phases.
// Depends on rfor_pkg, rfor_in_if, rfor_out_if and the rasterizer RTL.
module testbench;

    localparam int SCREEN_W = 800;
    localparam int SCREEN_H = 480;
    localparam int PX_BYTES = 2;
    localparam int RANDOM_BEATS = 400;

    typedef struct packed {
        logic             we;
        rfor_pkg::t_off   off;
        rfor_pkg::t_color color;
        logic             last;
    } t_px_write;

    typedef struct packed {
        logic               is_cfg;
        rfor_pkg::t_reg_idx reg_idx;
        rfor_pkg::t_coord   reg_val;
        logic               start_req;
        logic               outl;
        logic               excl;
        rfor_pkg::t_color   color;
        logic               typed;
        t_px_write          px;
    } t_dir_row;

    localparam t_px_write PX_IDLE = {1'b0, 22'd0, 24'd0, 1'b1};

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [rfor_pkg::APB_ADDR_W-1:0] paddr;
    logic [rfor_pkg::APB_DATA_W-1:0] pwdata;
    logic [rfor_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    rfor_in_if  in_if();
    rfor_out_if out_if();

    rect_fill_outline_rasterizer #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H),
        .PIXEL_BYTES   (PX_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rfor_pkg::t_cfg   shadow_cfg;
    rfor_pkg::t_coord scan_col_q;
    rfor_pkg::t_coord scan_row_q;
    logic             scan_busy;
    t_px_write        pending_px[$];
    t_dir_row         dir_rows[$];
    int               n_mismatch;
    int               n_results;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic t_px_write rasterize_step(logic start_req, logic outl, logic excl,
                                                 rfor_pkg::t_color color);
        t_px_write        r;
        logic [12:0]      x;
        logic [12:0]      y;
        rfor_pkg::t_coord last_col;
        rfor_pkg::t_coord last_row;
        logic             in_rect;
        logic             border;
        logic             draw;
        logic             end_row;
        logic             end_scan;
        int unsigned      off;
        r = PX_IDLE;
        if (start_req) begin
            scan_col_q = '0;
            scan_row_q = '0;
            scan_busy  = 1'b1;
        end
        if (scan_busy && (shadow_cfg.rect_w == 0 || shadow_cfg.rect_h == 0))
            scan_busy = 1'b0;
        if (!scan_busy)
            return r;
        last_col = shadow_cfg.rect_w - 12'd1;
        last_row = shadow_cfg.rect_h - 12'd1;
        x = {1'b0, shadow_cfg.rect_x} + {1'b0, scan_col_q};
        y = {1'b0, shadow_cfg.rect_y} + {1'b0, scan_row_q};
        in_rect = scan_col_q < shadow_cfg.rect_w && scan_row_q < shadow_cfg.rect_h;
        border = scan_col_q == 0 || scan_col_q == last_col ||
                 scan_row_q == 0 || scan_row_q == last_row;
        draw = in_rect && (!outl || border);
        if (x >= SCREEN_W || y >= SCREEN_H)
            draw = 1'b0;
        if (excl && x >= shadow_cfg.excl_left && x <= shadow_cfg.excl_right &&
            y >= shadow_cfg.excl_top && y <= shadow_cfg.excl_bottom)
            draw = 1'b0;
        end_row  = scan_col_q >= last_col;
        end_scan = end_row && scan_row_q >= last_row;
        r = '0;
        if (draw) begin
            off     = PX_BYTES * (SCREEN_W * y + x);
            r.we    = 1'b1;
            r.off   = off[21:0];
            r.color = color & rfor_pkg::LOW_COLOR_MASK;
            if (PX_BYTES >= 3)
                r.color = r.color | (color & rfor_pkg::HIGH_COLOR_BYTE);
        end
        r.last = end_scan;
        if (end_scan) begin
            scan_busy  = 1'b0;
            scan_col_q = '0;
            scan_row_q = '0;
        end else if (end_row) begin
            scan_col_q = '0;
            scan_row_q = scan_row_q + 12'd1;
        end else begin
            scan_col_q = scan_col_q + 12'd1;
        end
        return r;
    endfunction

    function automatic void dir_cfg(rfor_pkg::t_reg_idx idx, rfor_pkg::t_coord val);
        t_dir_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void dir_beat(logic s, logic o, logic e, rfor_pkg::t_color c,
                                     logic typed, t_px_write px);
        t_dir_row row;
        row = '0;
        row.start_req = s;
        row.outl      = o;
        row.excl      = e;
        row.color     = c;
        row.typed     = typed;
        row.px        = px;
        dir_rows.push_back(row);
    endfunction

    task automatic cfg_write(rfor_pkg::t_reg_idx idx, rfor_pkg::t_coord val);
        logic [rfor_pkg::APB_DATA_W-1:0] data;
        in_if.valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        data = $urandom;
        data[11:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rfor_pkg::REG_RECT_X:      shadow_cfg.rect_x      = val;
            rfor_pkg::REG_RECT_Y:      shadow_cfg.rect_y      = val;
            rfor_pkg::REG_RECT_W:      shadow_cfg.rect_w      = val;
            rfor_pkg::REG_RECT_H:      shadow_cfg.rect_h      = val;
            rfor_pkg::REG_EXCL_LEFT:   shadow_cfg.excl_left   = val;
            rfor_pkg::REG_EXCL_TOP:    shadow_cfg.excl_top    = val;
            rfor_pkg::REG_EXCL_RIGHT:  shadow_cfg.excl_right  = val;
            rfor_pkg::REG_EXCL_BOTTOM: shadow_cfg.excl_bottom = val;
            default: ;
        endcase
    endtask

    task automatic send_beat(logic s, logic o, logic e, rfor_pkg::t_color c, logic typed,
                             t_px_write px);
        int        r;
        int        gap;
        t_px_write want;
        r   = $urandom_range(0, 19);
        gap = (r < 12) ? 0 : (r < 19) ? $urandom_range(1, 3) : $urandom_range(8, 25);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.start_req  <= s;
        in_if.outline    <= o;
        in_if.exclude_on <= e;
        in_if.color      <= c;
        do @(posedge i_clk); while (!in_if.ready);
        want = rasterize_step(s, o, e, c);
        pending_px.push_back(typed ? px : want);
    endtask

    always @(posedge i_clk) begin : px_check
        t_px_write got;
        t_px_write want;
        if (out_if.valid && out_if.ready) begin
            n_results = n_results + 1;
            got = {out_if.write_enable, out_if.byte_offset, out_if.pixel_color, out_if.last};
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected pixel beat, actual we=%0b off=%0d color=%h last=%0b",
                         $time, got.we, got.off, got.color, got.last);
                n_mismatch = n_mismatch + 1;
            end else begin
                want = pending_px.pop_front();
                if (got.we !== want.we || got.off !== want.off ||
                    got.color !== want.color || got.last !== want.last) begin
                    $display("%0t: pixel beat mismatch, expected we=%0b off=%0d color=%h last=%0b",
                             $time, want.we, want.off, want.color, want.last);
                    $display("%0t:                        actual we=%0b off=%0d color=%h last=%0b",
                             $time, got.we, got.off, got.color, got.last);
                    n_mismatch = n_mismatch + 1;
                end
            end
        end
    end

    initial begin : sink_ready
        int   len;
        logic pressed;
        pressed = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!pressed && n_results >= 120) begin
                pressed = 1'b1;
                out_if.ready <= 1'b0;
                repeat (150) @(posedge i_clk);
            end else if ($urandom_range(0, 1) == 0) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 20);
                out_if.ready <= 1'b1;
                repeat (len - 1) @(posedge i_clk);
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 3);
                out_if.ready <= 1'b0;
                repeat (len - 1) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int               sent;
        int               kind;
        int               n;
        int               k;
        logic             o;
        logic             e;
        rfor_pkg::t_coord w;
        rfor_pkg::t_coord h;
        rfor_pkg::t_coord rx;
        rfor_pkg::t_coord ry;
        rfor_pkg::t_coord el;
        rfor_pkg::t_coord et;
        rfor_pkg::t_coord er;
        rfor_pkg::t_coord eb;

        n_mismatch = 0;
        n_results  = 0;
        shadow_cfg = '0;
        scan_col_q = '0;
        scan_row_q = '0;
        scan_busy  = 1'b0;

        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_if.valid      <= 1'b0;
        in_if.start_req  <= 1'b0;
        in_if.outline    <= 1'b0;
        in_if.exclude_on <= 1'b0;
        in_if.color      <= '0;

        // idle after reset, start on the empty reset rectangle
        dir_beat(1'b0, 1'b0, 1'b0, 24'h123456, 1'b1, PX_IDLE);
        dir_beat(1'b1, 1'b0, 1'b0, 24'hABCDEF, 1'b1, PX_IDLE);
        // 2x2 fill at the origin, then idle once the scan ends
        dir_cfg(rfor_pkg::REG_RECT_W, 12'd2);
        dir_cfg(rfor_pkg::REG_RECT_H, 12'd2);
        dir_beat(1'b1, 1'b0, 1'b0, 24'hFFFFFF, 1'b1, {1'b1, 22'd0, 24'h00FFFF, 1'b0});
        dir_beat(1'b0, 1'b0, 1'b0, 24'h000000, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b1, 1'b0, 24'h5A5A5A, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b0, 1'b0, 24'hFFFFFF, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b0, 1'b0, 24'h00FF00, 1'b1, PX_IDLE);
        // single row outline across the bottom-right screen corner
        dir_cfg(rfor_pkg::REG_RECT_X, 12'd799);
        dir_cfg(rfor_pkg::REG_RECT_Y, 12'd479);
        dir_cfg(rfor_pkg::REG_RECT_W, 12'd3);
        dir_cfg(rfor_pkg::REG_RECT_H, 12'd1);
        dir_beat(1'b1, 1'b1, 1'b0, 24'h80C3F1, 1'b1, {1'b1, 22'd767998, 24'h00C3F1, 1'b0});
        dir_beat(1'b0, 1'b1, 1'b0, 24'h7F0001, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b1, 1'b0, 24'hC00000, 1'b0, PX_IDLE);
        // everything off screen
        dir_cfg(rfor_pkg::REG_RECT_X, 12'd4095);
        dir_cfg(rfor_pkg::REG_RECT_Y, 12'd4095);
        dir_cfg(rfor_pkg::REG_RECT_W, 12'd4095);
        dir_cfg(rfor_pkg::REG_RECT_H, 12'd4095);
        dir_beat(1'b1, 1'b0, 1'b1, 24'hFFFFFF, 1'b1, {1'b0, 22'd0, 24'd0, 1'b0});
        // exclusion area covering the right column of a 2x2
        dir_cfg(rfor_pkg::REG_RECT_X, 12'd10);
        dir_cfg(rfor_pkg::REG_RECT_Y, 12'd10);
        dir_cfg(rfor_pkg::REG_RECT_W, 12'd2);
        dir_cfg(rfor_pkg::REG_RECT_H, 12'd2);
        dir_cfg(rfor_pkg::REG_EXCL_LEFT, 12'd11);
        dir_cfg(rfor_pkg::REG_EXCL_TOP, 12'd10);
        dir_cfg(rfor_pkg::REG_EXCL_RIGHT, 12'd11);
        dir_cfg(rfor_pkg::REG_EXCL_BOTTOM, 12'd11);
        dir_beat(1'b1, 1'b0, 1'b1, 24'h111111, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b0, 1'b1, 24'h222222, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b0, 1'b0, 24'h333333, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b1, 1'b1, 24'h444444, 1'b0, PX_IDLE);
        // inverted exclusion bounds exclude nothing
        dir_cfg(rfor_pkg::REG_EXCL_LEFT, 12'd4095);
        dir_beat(1'b1, 1'b0, 1'b1, 24'h555555, 1'b0, PX_IDLE);
        // shrink the width while a 4x3 outline scan is under way
        dir_cfg(rfor_pkg::REG_RECT_X, 12'd0);
        dir_cfg(rfor_pkg::REG_RECT_Y, 12'd0);
        dir_cfg(rfor_pkg::REG_RECT_W, 12'd4);
        dir_cfg(rfor_pkg::REG_RECT_H, 12'd3);
        dir_beat(1'b1, 1'b1, 1'b0, 24'h0F0F0F, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b1, 1'b0, 24'hF0F0F0, 1'b0, PX_IDLE);
        dir_cfg(rfor_pkg::REG_RECT_W, 12'd1);
        dir_beat(1'b0, 1'b1, 1'b0, 24'h123ABC, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b1, 1'b0, 24'hABC123, 1'b0, PX_IDLE);
        dir_beat(1'b0, 1'b1, 1'b0, 24'h876543, 1'b0, PX_IDLE);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            else
                send_beat(dir_rows[i].start_req, dir_rows[i].outl, dir_rows[i].excl,
                          dir_rows[i].color, dir_rows[i].typed, dir_rows[i].px);
        end

        sent = 0;
        while (sent < RANDOM_BEATS) begin
            kind = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0: w = 12'd0;
                1: w = 12'd4095;
                2: w = 12'd1;
                default: w = rfor_pkg::t_coord'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0: h = 12'd0;
                1: h = 12'd4095;
                2: h = 12'd1;
                default: h = rfor_pkg::t_coord'($urandom_range(1, 6));
            endcase
            if (kind == 7) begin
                // resize only, then carry on with the scan already in progress
                cfg_write(rfor_pkg::REG_RECT_W, w);
                cfg_write(rfor_pkg::REG_RECT_H, h);
                n = $urandom_range(4, 16);
                for (k = 0; k < n; k++)
                    send_beat(1'b0, 1'($urandom), 1'($urandom),
                              rfor_pkg::t_color'($urandom), 1'b0, PX_IDLE);
                sent += n;
            end else begin
                case ($urandom_range(0, 3))
                    0: rx = rfor_pkg::t_coord'($urandom_range(0, 799));
                    1: rx = rfor_pkg::t_coord'($urandom_range(790, 805));
                    2: rx = rfor_pkg::t_coord'($urandom);
                    default: rx = rfor_pkg::t_coord'($urandom_range(0, 8));
                endcase
                case ($urandom_range(0, 3))
                    0: ry = rfor_pkg::t_coord'($urandom_range(0, 479));
                    1: ry = rfor_pkg::t_coord'($urandom_range(470, 485));
                    2: ry = rfor_pkg::t_coord'($urandom);
                    default: ry = rfor_pkg::t_coord'($urandom_range(0, 8));
                endcase
                case ($urandom_range(0, 3))
                    0, 1: begin
                        el = rx + rfor_pkg::t_coord'($urandom_range(0, 2));
                        er = el + rfor_pkg::t_coord'($urandom_range(0, 2));
                        et = ry + rfor_pkg::t_coord'($urandom_range(0, 2));
                        eb = et + rfor_pkg::t_coord'($urandom_range(0, 2));
                    end
                    2: begin
                        el = rfor_pkg::t_coord'($urandom);
                        er = rfor_pkg::t_coord'($urandom);
                        et = rfor_pkg::t_coord'($urandom);
                        eb = rfor_pkg::t_coord'($urandom);
                    end
                    default: begin
                        el = 12'd0;
                        et = 12'd0;
                        er = 12'd4095;
                        eb = 12'd4095;
                    end
                endcase
                cfg_write(rfor_pkg::REG_RECT_X, rx);
                cfg_write(rfor_pkg::REG_RECT_Y, ry);
                cfg_write(rfor_pkg::REG_RECT_W, w);
                cfg_write(rfor_pkg::REG_RECT_H, h);
                cfg_write(rfor_pkg::REG_EXCL_LEFT, el);
                cfg_write(rfor_pkg::REG_EXCL_TOP, et);
                cfg_write(rfor_pkg::REG_EXCL_RIGHT, er);
                cfg_write(rfor_pkg::REG_EXCL_BOTTOM, eb);
                if (kind <= 4) begin
                    n = int'(w) * int'(h);
                    if (n == 0)
                        n = 1;
                    if (n > 48)
                        n = 48;
                    n += $urandom_range(0, 2);
                    o = 1'($urandom);
                    e = 1'($urandom);
                    for (k = 0; k < n; k++)
                        send_beat(k == 0, o, e, rfor_pkg::t_color'($urandom), 1'b0, PX_IDLE);
                end else begin
                    n = $urandom_range(5, 20);
                    for (k = 0; k < n; k++)
                        send_beat($urandom_range(0, 7) == 0, 1'($urandom), 1'($urandom),
                                  rfor_pkg::t_color'($urandom), 1'b0, PX_IDLE);
                end
                sent += n;
            end
        end

        in_if.valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/rfor_pkg.sv
rtl/rfor_in_if.sv
rtl/rfor_out_if.sv
rtl/rfor_cfg_regs.sv
rtl/rfor_scan_ctrl.sv
rtl/rfor_pixel_eval.sv
rtl/rect_fill_outline_rasterizer.sv
verif/testbench.sv
